// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fla_pkg.sv -----
// ----------------------------------------------------------------------------
// fla_pkg
// types, codes and constants of the free list page allocator
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int MAX_PAGES_DEF = 4096;

    // page size in bytes, a power of two
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int PAGE_W    = 28;
    localparam int ADDR_W    = 40;
    localparam int CNT_OUT_W = 13;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [PAGE_W-1:0] BASE_RESET = 28'd524288;
    localparam logic [PAGE_W-1:0] TOP_RESET  = 28'd528384;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_MISALIGNED = 3'd2,
        STAT_RANGE      = 3'd3,
        STAT_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic {
        REG_BASE = 1'b0,
        REG_TOP  = 1'b1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        mode_t              mode;
        logic [ADDR_W-1:0]  address;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [ADDR_W-1:0]     page_address;
        logic [CNT_OUT_W-1:0]  free_count;
        logic [CNT_OUT_W-1:0]  used_count;
        logic [CNT_OUT_W-1:0]  total_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic rsp_valid;
    } dp_sts_t;

endpackage

// ----- rtl/core/fla_cfg.sv -----
// ----------------------------------------------------------------------------
// fla_cfg
// apb register bank holding base_page and top_page
// ----------------------------------------------------------------------------
module fla_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fla_pkg::APB_AW-1:0]   paddr,
    input  logic [fla_pkg::APB_DW-1:0]   pwdata,
    output logic [fla_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [fla_pkg::PAGE_W-1:0]   base_page,
    output logic [fla_pkg::PAGE_W-1:0]   top_page
);
    import fla_pkg::*;

    logic [PAGE_W-1:0] base_reg;
    logic [PAGE_W-1:0] top_reg;
    logic              wr_en;
    reg_index_t        sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    // word index, low byte bits ignored
    assign sel    = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            top_reg  <= TOP_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_BASE: base_reg <= pwdata[PAGE_W-1:0];
                REG_TOP:  top_reg  <= pwdata[PAGE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_BASE: prdata = {{(APB_DW-PAGE_W){1'b0}}, base_reg};
            REG_TOP:  prdata = {{(APB_DW-PAGE_W){1'b0}}, top_reg};
            default:  prdata = '0;
        endcase
    end

    assign base_page = base_reg;
    assign top_page  = top_reg;

endmodule

// ----- rtl/core/fla_ctrl.sv -----
// ----------------------------------------------------------------------------
// fla_ctrl
// two-state sequencer: capture a request, then commit its result
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              rsp_ready,
    input  fla_pkg::dp_sts_t  sts,
    output fla_pkg::dp_cmd_t  cmd
);
    import fla_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       slot_free;

    // output register empty or draining this cycle
    assign slot_free = !sts.rsp_valid || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_EXEC;
            ST_EXEC: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_EXEC: cmd.commit = slot_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/fla_dp.sv -----
// ----------------------------------------------------------------------------
// fla_dp
// allocator datapath: freed stack memory, counters and result register
// ----------------------------------------------------------------------------
module fla_dp #(
    parameter int MAX_PAGES = fla_pkg::MAX_PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fla_pkg::dp_cmd_t            cmd,
    output fla_pkg::dp_sts_t            sts,
    input  fla_pkg::req_t               req,
    input  logic [fla_pkg::PAGE_W-1:0]  base_page,
    input  logic [fla_pkg::PAGE_W-1:0]  top_page,
    input  logic                        rsp_ready,
    output fla_pkg::rsp_t               rsp
);
    import fla_pkg::*;

    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [CW-1:0]     MAX_C  = CW'(MAX_PAGES);
    localparam logic [PAGE_W-1:0] MAX_PW = PAGE_W'(MAX_PAGES);

    logic [AW-1:0]     stack_mem [MAX_PAGES];
    logic [AW-1:0]     rd_data_reg;

    mode_t             mode_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [CW-1:0]     depth_reg,  depth_next;
    logic [CW-1:0]     fresh_reg,  fresh_next;
    logic [CW-1:0]     total_reg,  total_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg,    rsp_next;

    logic              push;
    logic [AW-1:0]     push_off;
    logic [AW-1:0]     alloc_off;
    logic [PAGE_W-1:0] span;
    logic [ADDR_W-1:0] page_num;
    logic [ADDR_W-1:0] page_lim;
    logic [PAGE_W:0]   page_sum;
    logic [CW:0]       free_now;
    logic [CW:0]       free_after;

    // stack memory, read at capture so the pop data is ready in exec
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_data_reg <= stack_mem[AW'(depth_reg - 1'b1)];
        if (cmd.commit && push)
            stack_mem[depth_reg[AW-1:0]] <= push_off;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= req.mode;
            addr_reg <= req.address;
        end
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            fresh_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                depth_reg <= depth_next;
                fresh_reg <= fresh_next;
                total_reg <= total_next;
            end
            if (cmd.commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign span     = top_page - base_page;
    assign page_num = addr_reg >> PAGE_SHIFT;
    assign page_lim = ADDR_W'(base_page) + ADDR_W'(total_reg);
    assign push_off = AW'(page_num - ADDR_W'(base_page));
    assign free_now = (CW+1)'(depth_reg) + (CW+1)'(total_reg - fresh_reg);

    always_comb
    begin
        depth_next = depth_reg;
        fresh_next = fresh_reg;
        total_next = total_reg;
        push       = 1'b0;
        alloc_off  = rd_data_reg;
        rsp_next   = '0;
        rsp_next.status = STAT_OK;

        case (mode_reg)
            MODE_INIT:
            begin
                if (top_page <= base_page)
                    total_next = '0;
                else if (span > MAX_PW)
                    total_next = MAX_C;
                else
                    total_next = CW'(span);
                depth_next = '0;
                fresh_next = '0;
            end
            MODE_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - 1'b1;
                    alloc_off  = rd_data_reg;
                end
                else if (fresh_reg < total_reg)
                begin
                    fresh_next = fresh_reg + 1'b1;
                    alloc_off  = AW'(fresh_reg);
                end
                else
                    rsp_next.status = STAT_EMPTY;
            end
            MODE_FREE:
            begin
                if (addr_reg[PAGE_SHIFT-1:0] != '0)
                    rsp_next.status = STAT_MISALIGNED;
                else if (page_num < ADDR_W'(base_page) || page_num >= page_lim)
                    rsp_next.status = STAT_RANGE;
                else if (free_now >= (CW+1)'(MAX_PAGES) || depth_reg >= MAX_C)
                    rsp_next.status = STAT_OVERFLOW;
                else
                begin
                    push       = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            default: ;
        endcase

        page_sum = (PAGE_W+1)'(base_page) + (PAGE_W+1)'(alloc_off);
        if (mode_reg == MODE_ALLOC && rsp_next.status == STAT_OK)
            rsp_next.page_address = ADDR_W'(64'(page_sum) << PAGE_SHIFT);

        free_after = (CW+1)'(depth_next) + (CW+1)'(total_next - fresh_next);
        rsp_next.free_count  = CNT_OUT_W'(free_after);
        rsp_next.total_count = CNT_OUT_W'(total_next);
        if ((CW+1)'(total_next) > free_after)
            rsp_next.used_count = CNT_OUT_W'((CW+1)'(total_next) - free_after);
        else
            rsp_next.used_count = '0;
    end

    assign sts.rsp_valid = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule

// ----- rtl/core/free_list_page_allocator.sv -----
// ----------------------------------------------------------------------------
// free_list_page_allocator
// physical page allocator with a lifo list of freed pages and a counter of
// untouched pages, apb configured base and top page numbers
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  req       in         req_valid/req_ready  mode, address
//  rsp       out        rsp_valid/rsp_ready  status, page_address, counts
//  apb       in/out     psel/penable/pready  base_page @0x0, top_page @0x4
//
//  each request is first captured, which reads the top of the freed stack
//  out of its synchronous memory port, and then its result is committed
//  reset clears counters, state machine and result valid; the stack memory
//  is not cleared, only pushed entries are ever popped
//  a result held by rsp_ready low stalls the commit cycle; the next request
//  is taken as soon as the previous result has been loaded
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module free_list_page_allocator #(
    parameter int MAX_PAGES = fla_pkg::MAX_PAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_ready,
    input  fla_pkg::req_t                req,
    // result channel
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output fla_pkg::rsp_t                rsp,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fla_pkg::APB_AW-1:0]   paddr,
    input  logic [fla_pkg::APB_DW-1:0]   pwdata,
    output logic [fla_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import fla_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [PAGE_W-1:0] base_page;
    logic [PAGE_W-1:0] top_page;

    // register bank, read live by the datapath
    fla_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .base_page (base_page),
        .top_page  (top_page)
    );

    // sequencer: capture then commit
    fla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stack memory, counters and result register
    fla_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .base_page (base_page),
        .top_page  (top_page),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_valid = sts.rsp_valid;

    // one request in flight: after a capture the port stays closed until the result is committed
    `CHK_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
    // capture and commit belong to different states
    `CHK_NOW(a_cmd_exclusive, cmd.capture, !cmd.commit, "capture and commit together")
    // only a successful result carries a page address
    `CHK_NOW(a_addr_on_ok, rsp_valid && rsp.status != STAT_OK, rsp.page_address == '0,
        "page address on failed result")

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the free list page allocator: requests are queued
// by a stimulus process, offered in bursts with random gaps, and every
// accepted request runs through a cycle-free allocator predictor whose
// result is matched field by field against the returned word
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fla_pkg::*;

    localparam int MAX_PAGES   = MAX_PAGES_DEF;
    localparam int OFF_W       = $clog2(MAX_PAGES);
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 70;

    typedef enum logic [1:0] {
        RDY_ALWAYS  = 2'd0,
        RDY_PATTERN = 2'd1,
        RDY_RANDOM  = 2'd2
    } ready_style_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // request words waiting to be offered, result words still owed
    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];

    // allocator predictor: its own copy of the registers and the free list
    logic [PAGE_W-1:0] cfg_base = BASE_RESET;
    logic [PAGE_W-1:0] cfg_top  = TOP_RESET;
    logic [OFF_W-1:0]  pm_stack [MAX_PAGES];
    int                pm_depth = 0;
    int                pm_fresh = 0;
    int                pm_total = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;
    bit no_idle    = 1'b0;

    // receiver pacing
    ready_style_t      ready_style = RDY_RANDOM;
    logic [15:0]       ready_pat   = 16'hB6DB;
    int                pat_pos     = 0;
    int                hold_req    = 0;
    int                hold_done   = 0;
    int                hold_left   = 0;

    // bookkeeping
    int n_errors   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_cfg      = 0;
    int status_seen [5];
    int cycle_cnt  = 0;

    free_list_page_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // byte address of a page number, cut to the address field width
    function automatic logic [ADDR_W-1:0] page_addr(logic [63:0] page);
        logic [63:0] byte_addr;
        byte_addr = page << PAGE_SHIFT;
        return byte_addr[ADDR_W-1:0];
    endfunction

    // applies one request to the predicted allocator and returns its word
    function automatic rsp_t predict_page_result(req_t r);
        rsp_t        o;
        logic [63:0] span;
        logic [63:0] page;
        logic [63:0] avail;
        o        = '0;
        o.status = STAT_OK;
        case (r.mode)
            MODE_INIT:
            begin
                // top at or below base manages nothing
                span = 0;
                if (cfg_top > cfg_base)
                begin
                    span = 64'(cfg_top) - 64'(cfg_base);
                    if (span > MAX_PAGES)
                        span = MAX_PAGES;
                end
                pm_total = int'(span);
                pm_depth = 0;
                pm_fresh = 0;
            end
            MODE_ALLOC:
            begin
                // freed pages first, lifo, then untouched pages in order
                if (pm_depth > 0)
                begin
                    pm_depth--;
                    o.page_address = page_addr(64'(cfg_base) + 64'(pm_stack[pm_depth]));
                end
                else if (pm_fresh < pm_total)
                begin
                    o.page_address = page_addr(64'(cfg_base) + 64'(pm_fresh));
                    pm_fresh++;
                end
                else
                    o.status = STAT_EMPTY;
            end
            MODE_FREE:
            begin
                page  = 64'(r.address) >> PAGE_SHIFT;
                avail = 64'(pm_depth + pm_total - pm_fresh);
                if (r.address[PAGE_SHIFT-1:0] != '0)
                    o.status = STAT_MISALIGNED;
                else if (page < 64'(cfg_base) || page >= 64'(cfg_base) + 64'(pm_total))
                    o.status = STAT_RANGE;
                else if (avail >= MAX_PAGES || pm_depth >= MAX_PAGES)
                    o.status = STAT_OVERFLOW;
                else
                begin
                    // no double-free check, counts may rise above total
                    pm_stack[pm_depth] = OFF_W'(page - 64'(cfg_base));
                    pm_depth++;
                end
            end
            default: ;  // query: no state change
        endcase
        avail         = 64'(pm_depth + pm_total - pm_fresh);
        o.free_count  = avail[CNT_OUT_W-1:0];
        o.used_count  = (64'(pm_total) > avail) ?
                        CNT_OUT_W'(64'(pm_total) - avail) : '0;
        o.total_count = CNT_OUT_W'(pm_total);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: offers queued words in bursts, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp_q.push_back(predict_page_result(req));
                n_accepted++;
            end
            // a new word may go out once the current one is taken
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_req_q.size() > 0)
                begin
                    req       <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = no_idle ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: stall pattern of its own, plus long hold-offs on demand
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
            if (hold_left == 0)
                hold_done++;
        end
        else if (hold_req != hold_done)
        begin
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case (ready_style)
                RDY_ALWAYS:  rsp_ready <= 1'b1;
                RDY_PATTERN:
                begin
                    rsp_ready <= ready_pat[pat_pos];
                    pat_pos = (pat_pos + 1) % 16;
                end
                default:     rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            n_errors++;
            $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_results++;
            if (rsp.status <= STAT_OVERFLOW)
                status_seen[rsp.status]++;
            if (expected_rsp_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result word, expected none, actual 0x%0h",
                         $realtime, rsp);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("status",       64'(want.status),       64'(rsp.status));
                check_field("page_address", 64'(want.page_address), 64'(rsp.page_address));
                check_field("free_count",   64'(want.free_count),   64'(rsp.free_count));
                check_field("used_count",   64'(want.used_count),   64'(rsp.used_count));
                check_field("total_count",  64'(want.total_count),  64'(rsp.total_count));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $realtime,
                     expected_rsp_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(mode_t m, logic [ADDR_W-1:0] a);
        req_t r;
        r.mode    = m;
        r.address = a;
        pending_req_q.push_back(r);
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // block is idle: nothing queued, nothing offered, nothing owed
    task automatic wait_drained();
        @(negedge clk);
        while (pending_req_q.size() > 0 || req_valid || expected_rsp_q.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // apb read of one register, compared on the register width
    task automatic cfg_check(reg_index_t idx, logic [PAGE_W-1:0] value);
        logic [APB_DW-1:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[PAGE_W-1:0] !== value)
        begin
            n_errors++;
            $display("%0t: register %s read back: expected 0x%0h, actual 0x%0h",
                     $realtime, idx.name(), value, rd[PAGE_W-1:0]);
        end
    endtask

    // apb write, upper data bits random since the register drops them
    task automatic cfg_write(reg_index_t idx, logic [PAGE_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {4'($urandom_range(0, 15)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        if (idx == REG_BASE)
            cfg_base = value;
        else
            cfg_top = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg++;
        cfg_check(idx, value);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [63:0]       base_word;
        logic [63:0]       span;
        logic [PAGE_W-1:0] new_base;
        logic [PAGE_W-1:0] new_top;
        int                kind;
        int                pick;

        foreach (status_seen[k])
            status_seen[k] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers come out of reset with BASE_RESET and TOP_RESET
        cfg_check(REG_BASE, BASE_RESET);
        cfg_check(REG_TOP, TOP_RESET);

        // before any init nothing is managed
        base_word = 64'(BASE_RESET);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, page_addr(base_word));
        push_req(MODE_FREE, page_addr(base_word) | 40'h1);
        push_req(MODE_QUERY, '0);

        // init with reset registers spans exactly the list size, a full list: a free overflows
        push_req(MODE_INIT, '0);
        push_req(MODE_FREE, page_addr(base_word));
        push_req(MODE_ALLOC, '0);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, page_addr(base_word));
        // double free is accepted, then the list is full again
        push_req(MODE_FREE, page_addr(base_word));
        push_req(MODE_FREE, page_addr(base_word + 1));
        push_req(MODE_ALLOC, '0);
        // range edges and address extremes
        push_req(MODE_FREE, page_addr(base_word - 1));
        push_req(MODE_FREE, page_addr(base_word + MAX_PAGES));
        push_req(MODE_FREE, 40'hFF_FFFF_FFFF);
        push_req(MODE_FREE, 40'hFF_FFFF_F000);
        push_req(MODE_QUERY, 40'hFF_FFFF_FFFF);
        wait_drained();

        // top at base manages nothing
        cfg_write(REG_BASE, '0);
        cfg_write(REG_TOP, '0);
        push_req(MODE_INIT, '0);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, '0);
        wait_drained();

        // highest pages, then a live base change pushes the address past 40 bits
        cfg_write(REG_BASE, 28'hFFF_F000);
        cfg_write(REG_TOP, 28'hFFF_FFFF);
        push_req(MODE_INIT, '0);
        push_req(MODE_ALLOC, '0);
        wait_drained();
        cfg_write(REG_BASE, 28'hFFF_FFFF);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, 40'hFF_FFFF_F000);
        push_req(MODE_ALLOC, '0);
        wait_drained();

        // random phases, each with its own registers and pacing
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    // top at or below base
                    new_base = 28'($urandom);
                    new_top  = 28'($urandom_range(0, int'(new_base)));
                end
                1, 2:
                begin
                    // near or beyond the list size, clamped beyond it
                    new_base = 28'($urandom_range(0, 28'hFFF_0000));
                    new_top  = new_base + 28'($urandom_range(MAX_PAGES - 8, 3 * MAX_PAGES));
                end
                3:
                begin
                    // top pinned at the register maximum
                    new_top  = 28'hFFF_FFFF;
                    new_base = new_top - 28'($urandom_range(1, 16));
                end
                4:
                begin
                    new_base = '0;
                    new_top  = 28'($urandom_range(1, 16));
                end
                default:
                begin
                    new_base = 28'($urandom_range(0, 28'hFFF_0000));
                    new_top  = new_base + 28'($urandom_range(1, 16));
                end
            endcase
            cfg_write(REG_BASE, new_base);
            cfg_write(REG_TOP, new_top);
            span = (new_top > new_base) ? 64'(new_top - new_base) : 0;
            if (span > MAX_PAGES)
                span = MAX_PAGES;
            base_word = 64'(new_base);

            // pacing for this phase
            no_idle     = ($urandom_range(0, 3) == 0);
            ready_style = ready_style_t'($urandom_range(0, 2));
            ready_pat   = 16'($urandom) | 16'h1;
            if (ph == 2)
            begin
                // receiver holds off while the sender keeps offering
                no_idle     = 1'b1;
                ready_style = RDY_ALWAYS;
            end

            push_req(MODE_INIT, rand_addr());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    push_req(MODE_ALLOC, rand_addr());
                else if (pick < 80)
                    push_req(MODE_FREE, page_addr(base_word +
                             ((span > 0) ? $urandom_range(0, int'(span) - 1) : 0)));
                else if (pick < 85)
                    push_req(MODE_FREE, page_addr(base_word + $urandom_range(0, 16)) |
                             ADDR_W'($urandom_range(1, PAGE_BYTES - 1)));
                else if (pick < 90)
                    push_req(MODE_FREE, ($urandom_range(0, 1) == 0) ?
                             page_addr(base_word - 1) : page_addr(base_word + span));
                else if (pick < 94)
                    push_req(MODE_FREE, rand_addr());
                else if (pick < 98)
                    push_req(MODE_QUERY, rand_addr());
                else
                    push_req(MODE_INIT, rand_addr());

                // sender pauses until every owed result is back
                if (i == PHASE_ITEMS / 2)
                begin
                    if (ph == 2)
                        hold_req++;
                    wait_drained();
                    // sometimes move the registers mid-phase, base acts at once
                    if ($urandom_range(0, 3) == 0)
                        cfg_write(REG_BASE, new_base + 28'($urandom_range(0, 2)) - 28'd1);
                    if ($urandom_range(0, 3) == 0)
                        cfg_write(REG_TOP, 28'($urandom));
                    base_word = 64'(cfg_base);
                end
            end
            wait_drained();
        end

        // let any late word show up before the verdict
        repeat (20) @(negedge clk);

        $display("covered %0d requests, %0d results, %0d register writes",
                 n_accepted, n_results, n_cfg);
        $display("status mix ok %0d, empty %0d, misaligned %0d, range %0d, overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (n_errors == 0 && expected_rsp_q.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d errors, %0d results never arrived", n_errors,
                     expected_rsp_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
